// ===== rtl/dur_pkg.sv =====
// Shared types, codes and constants for the duplex UART relay.
`default_nettype none
package dur_pkg;

   localparam int FIFO_DEPTH_DEF = 64;
   localparam int TICK_WIDTH_DEF = 8;

   localparam logic [7:0] GAP_TIMEOUT_RST = 8'hFA;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_LOAD = 2'd1;
   localparam logic [1:0] REQ_ARM  = 2'd2;

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_WAIT  = 2'd1;
   localparam logic [1:0] MODE_FRAME = 2'd2;
   localparam logic [1:0] MODE_GAP   = 2'd3;

   localparam logic [3:0] SLOT_FIRST = 4'd0;
   localparam logic [3:0] SLOT_LAST  = 4'd9;

   typedef struct packed {
      logic [1:0] req_type;
      logic       rx_level;
      logic [7:0] load_byte;
   } req_word_type;

   typedef struct packed {
      logic       tx_level;
      logic       rx_byte_valid;
      logic [7:0] rx_byte;
      logic       frame_error;
      logic       fifo_overflow;
      logic [6:0] fifo_count;
      logic [1:0] block_state;
   } rsp_word_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } fifo_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   // tick at which each bit of the frame is sampled
   function automatic logic [4:0] slot_time(input logic [3:0] slot);
      logic [4:0] t;
      begin
         case (slot)
            4'd0:    t = 5'd2;
            4'd1:    t = 5'd5;
            4'd2:    t = 5'd8;
            4'd3:    t = 5'd12;
            4'd4:    t = 5'd15;
            4'd5:    t = 5'd18;
            4'd6:    t = 5'd21;
            4'd7:    t = 5'd25;
            4'd8:    t = 5'd28;
            default: t = 5'd31;
         endcase
         return t;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/duplex_uart_relay_with_fifo.sv =====
// Top level: tick-driven full-duplex 8N1 UART relay with byte FIFO.
//
//   channel  dir  ports                            word
//   req      in   req_valid req_ready req_data     req_word_type
//   rsp      out  rsp_valid rsp_ready rsp_data     rsp_word_type
//   csr      in   csr_wr_en csr_wr_data            gap timeout, 8 bits
//
// One word per cycle while req_ready is high: a word is processed in the cycle it is
// accepted and its response sits in the output register from the next cycle on.
// The FIFO head byte is prefetched into a register, so it is ready to send when popped.
// Synchronous reset returns to idle, empty FIFO, gap timeout 250.
// req_ready drops only while a response waits in the output register and
// rsp_ready is low.
`default_nettype none
module duplex_uart_relay_with_fifo import dur_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [7:0]   csr_wr_data
);

   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam int CW = (TICK_WIDTH > 8) ? TICK_WIDTH : 8;
   localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

   logic [1:0]            mode_ff, mode_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [3:0]            slot_ff, slot_in;
   logic [9:0]            rx_frame_ff, rx_frame_in;
   logic [9:0]            tx_frame_ff, tx_frame_in;
   logic                  tx_line_ff, tx_line_in;
   logic [7:0]            gap_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_data_ff, rsp_data_in;

   fifo_cmd_type          fcmd;
   fifo_stat_type         fstat;
   logic [7:0]            head_data;
   logic [FW-1:0]         fill_next;

   logic                  accept;
   logic [TICK_WIDTH-1:0] tick_inc;
   logic [3:0]            slot;
   logic [9:0]            rx_cur, tx_cur;
   logic                  go;
   logic                  valid, ferr, ovf;
   logic [7:0]            rbyte;

   dur_fifo #(.FIFO_DEPTH(FIFO_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .cmd       (fcmd),
      .stat      (fstat),
      .head_data (head_data),
      .fill_next (fill_next)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign tick_inc  = (tick_ff != TICK_MAX) ? tick_ff + TICK_WIDTH'(1) : tick_ff;
   assign slot      = (slot_ff > SLOT_LAST) ? SLOT_LAST : slot_ff;

   always_comb begin
      mode_in     = mode_ff;
      tick_in     = tick_ff;
      slot_in     = slot_ff;
      rx_frame_in = rx_frame_ff;
      tx_frame_in = tx_frame_ff;
      tx_line_in  = tx_line_ff;
      fcmd        = '0;
      valid       = 1'b0;
      rbyte       = '0;
      ferr        = 1'b0;
      ovf         = 1'b0;
      go          = 1'b0;
      rx_cur      = rx_frame_ff;
      tx_cur      = tx_frame_ff;
      if (accept) begin
         case (req_data.req_type)
            REQ_LOAD: begin
               if (fstat.full) begin
                  ovf = 1'b1;
               end else begin
                  fcmd.push = 1'b1;
                  fcmd.data = req_data.load_byte;
               end
            end
            REQ_ARM: begin
               if (mode_ff == MODE_IDLE) begin
                  mode_in = MODE_WAIT;
               end
            end
            REQ_TICK: begin
               case (mode_ff)
                  MODE_WAIT: begin
                     if (!req_data.rx_level) begin
                        tick_in = '0;
                        slot_in = SLOT_FIRST;
                        mode_in = MODE_FRAME;
                     end
                  end
                  MODE_GAP: begin
                     tick_in = tick_inc;
                     if (!req_data.rx_level || (CW'(tick_inc) >= CW'(gap_ff))
                         || (tick_inc == TICK_MAX)) begin
                        tick_in = '0;
                        slot_in = SLOT_FIRST;
                        mode_in = MODE_FRAME;
                     end
                  end
                  MODE_FRAME: begin
                     tick_in = tick_inc;
                     if (tick_inc >= TICK_WIDTH'(slot_time(slot))) begin
                        go = 1'b1;
                        if (slot == SLOT_FIRST) begin
                           if (fstat.empty) begin
                              mode_in = MODE_IDLE;
                              go      = 1'b0;
                           end else begin
                              tx_cur   = {1'b1, head_data, 1'b0};
                              rx_cur   = '0;
                              fcmd.pop = 1'b1;
                           end
                        end
                        if (go) begin
                           rx_cur[slot] = rx_cur[slot] | req_data.rx_level;
                           tx_line_in   = tx_cur[0];
                           tx_frame_in  = {1'b0, tx_cur[9:1]};
                           rx_frame_in  = rx_cur;
                           if (slot == SLOT_LAST) begin
                              tick_in = '0;
                              slot_in = SLOT_FIRST;
                              if (rx_cur[9] && !rx_cur[0]) begin
                                 valid   = 1'b1;
                                 rbyte   = rx_cur[8:1];
                                 mode_in = MODE_GAP;
                                 if (fstat.full) begin
                                    ovf = 1'b1;
                                 end else begin
                                    fcmd.push = 1'b1;
                                    fcmd.data = rx_cur[8:1];
                                 end
                              end else begin
                                 ferr    = 1'b1;
                                 mode_in = MODE_FRAME;
                              end
                           end else begin
                              slot_in = slot + 4'd1;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      rsp_data_in.tx_level      = tx_line_in;
      rsp_data_in.rx_byte_valid = valid;
      rsp_data_in.rx_byte       = rbyte;
      rsp_data_in.frame_error   = ferr;
      rsp_data_in.fifo_overflow = ovf;
      rsp_data_in.fifo_count    = 7'(fill_next);
      rsp_data_in.block_state   = mode_in;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         tick_ff      <= '0;
         slot_ff      <= SLOT_FIRST;
         rx_frame_ff  <= '0;
         tx_frame_ff  <= '0;
         tx_line_ff   <= 1'b0;
         gap_ff       <= GAP_TIMEOUT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         tick_ff      <= tick_in;
         slot_ff      <= slot_in;
         rx_frame_ff  <= rx_frame_in;
         tx_frame_ff  <= tx_frame_in;
         tx_line_ff   <= tx_line_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            gap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response word dropped or changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("input stalled with empty output");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_LAST) else $error("bit slot beyond stop bit");

endmodule
`default_nettype wire

// ===== rtl/dur_fifo.sv =====
// Byte FIFO with registered head prefetch for the UART relay.
`default_nettype none
module dur_fifo import dur_pkg::*; #(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
   localparam int FW = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire fifo_cmd_type  cmd,
   output fifo_stat_type      stat,
   output logic [7:0]         head_data,
   output logic [FW-1:0]      fill_next
);

   logic [7:0]    store_ff [FIFO_DEPTH];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [FW-1:0] fill_ff, fill_in;

   localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
   localparam logic [FW-1:0] DEPTH_FILL = FW'(FIFO_DEPTH);

   assign stat       = {(fill_ff == '0), (fill_ff == DEPTH_FILL)};
   assign head_data  = rdata_ff;
   assign fill_next  = fill_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (cmd.push) begin
         tail_in = (tail_ff == LAST_IDX) ? '0 : tail_ff + AW'(1);
         fill_in = fill_ff + FW'(1);
      end
      if (cmd.pop) begin
         head_in = (head_ff == LAST_IDX) ? '0 : head_ff + AW'(1);
         fill_in = fill_in - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // rdata_ff always mirrors the entry at the head; bypass a write to that entry
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_ff[tail_ff] <= cmd.data;
      end
      if (cmd.push && (tail_ff == head_in)) begin
         rdata_ff <= cmd.data;
      end else begin
         rdata_ff <= store_ff[head_in];
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty) else $error("pop from empty fifo");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full) else $error("push into full fifo");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_FILL) else $error("fifo fill beyond depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && !cmd.pop) |=> (fill_ff == $past(fill_ff) + FW'(1)))
      else $error("fill did not track push");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for the duplex UART relay: directed table, then random frames vs. a predictor.
module tb_top;
   import dur_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int DIR_ROWS = 21;
   localparam int PHASES = 6;
   localparam int WORDS_PER_PHASE = 200;
   localparam int CYCLE_LIMIT = 400000;
   // tick at which each frame bit is taken, slot 0 in the low bits
   localparam logic [49:0] BIT_TICKS = {5'd31, 5'd28, 5'd25, 5'd21, 5'd18,
                                        5'd15, 5'd12, 5'd8, 5'd5, 5'd2};

   typedef struct packed {
      logic [1:0] kind;
      logic       rx;
      logic [7:0] data;
      logic       typed;
      logic [6:0] count;
      logic [1:0] state;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [7:0]   csr_wr_data = '0;

   // relay state as predicted
   logic [7:0] relay_mem [FIFO_DEPTH_DEF];
   logic [5:0] relay_head;
   logic [5:0] relay_tail;
   logic [6:0] relay_fill;
   logic [7:0] relay_ticks;
   logic [3:0] relay_slot;
   logic [9:0] relay_rx_bits;
   logic [9:0] relay_tx_bits;
   logic [1:0] relay_mode;
   logic       relay_tx;
   logic [7:0] relay_gap;

   rsp_word_type queued_rsp [$];
   dir_row_type  dir_rows [DIR_ROWS];
   logic [7:0]   gap_list [PHASES];
   int           load_pct_list [PHASES];
   logic [9:0]   frame_plan = 10'h3FE;
   int           gap_plan = 0;
   int           load_pct = 4;
   int           send_idle_pct = 0;
   int           rsp_idle_pct = 0;
   int           rsp_hold_cycles = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;

   duplex_uart_relay_with_fifo DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   task automatic relay_reset();
      relay_head = '0;
      relay_tail = '0;
      relay_fill = '0;
      relay_ticks = '0;
      relay_slot = '0;
      relay_rx_bits = '0;
      relay_tx_bits = '0;
      relay_mode = MODE_IDLE;
      relay_tx = 1'b0;
      relay_gap = GAP_TIMEOUT_RST;
   endtask

   // returns 1 when the byte is dropped
   function automatic logic fifo_put(input logic [7:0] b);
      if (relay_fill >= FIFO_DEPTH_DEF)
         return 1'b1;
      relay_mem[relay_tail] = b;
      relay_tail = relay_tail + 1'b1;
      relay_fill = relay_fill + 1'b1;
      return 1'b0;
   endfunction

   task automatic frame_restart();
      relay_ticks = '0;
      relay_slot = SLOT_FIRST;
      relay_mode = MODE_FRAME;
   endtask

   task automatic uart_relay_step(input req_word_type w, output rsp_word_type r);
      logic [3:0] s;
      logic       go;
      r = '0;
      case (w.req_type)
         REQ_LOAD: r.fifo_overflow = fifo_put(w.load_byte);
         REQ_ARM: if (relay_mode == MODE_IDLE) relay_mode = MODE_WAIT;
         REQ_TICK: begin
            if (relay_mode == MODE_WAIT) begin
               if (!w.rx_level) frame_restart();
            end else if (relay_mode == MODE_GAP) begin
               if (relay_ticks != 8'hFF) relay_ticks = relay_ticks + 1'b1;
               if (!w.rx_level || relay_ticks >= relay_gap || relay_ticks == 8'hFF)
                  frame_restart();
            end else if (relay_mode == MODE_FRAME) begin
               s = (relay_slot <= SLOT_LAST) ? relay_slot : SLOT_LAST;
               if (relay_ticks != 8'hFF) relay_ticks = relay_ticks + 1'b1;
               if (relay_ticks >= BIT_TICKS[s*5 +: 5]) begin
                  go = 1'b1;
                  if (s == SLOT_FIRST) begin
                     if (relay_fill == 0) begin
                        relay_mode = MODE_IDLE;
                        go = 1'b0;
                     end else begin
                        relay_tx_bits = {1'b1, relay_mem[relay_head], 1'b0};
                        relay_head = relay_head + 1'b1;
                        relay_fill = relay_fill - 1'b1;
                        relay_rx_bits = '0;
                     end
                  end
                  if (go) begin
                     if (w.rx_level) relay_rx_bits[s] = 1'b1;
                     relay_tx = relay_tx_bits[0];
                     relay_tx_bits = relay_tx_bits >> 1;
                     if (s == SLOT_LAST) begin
                        if (relay_rx_bits[9] && !relay_rx_bits[0]) begin
                           r.rx_byte = relay_rx_bits[8:1];
                           r.rx_byte_valid = 1'b1;
                           r.fifo_overflow = fifo_put(relay_rx_bits[8:1]);
                           relay_mode = MODE_GAP;
                           relay_ticks = '0;
                           relay_slot = SLOT_FIRST;
                        end else begin
                           r.frame_error = 1'b1;
                           frame_restart();
                        end
                     end else begin
                        relay_slot = s + 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      r.tx_level = relay_tx;
      r.fifo_count = relay_fill;
      r.block_state = relay_mode;
   endtask

   // picks the next word from the predicted state: mostly well-formed frames
   task automatic make_word(output req_word_type w);
      logic [7:0] b;
      w.req_type = REQ_TICK;
      w.rx_level = 1'($urandom_range(0, 1));
      w.load_byte = 8'($urandom_range(0, 255));
      if (chance(2)) begin
         w.req_type = chance(50) ? REQ_UNUSED : REQ_ARM;
      end else if (chance(load_pct)) begin
         w.req_type = REQ_LOAD;
      end else begin
         case (relay_mode)
            MODE_IDLE: begin
               if (chance(10))
                  w.req_type = REQ_TICK;
               else if (relay_fill == 0 || chance(55))
                  w.req_type = REQ_LOAD;
               else
                  w.req_type = REQ_ARM;
            end
            MODE_WAIT: w.rx_level = !chance(40);
            MODE_FRAME: begin
               if (relay_ticks == 0 && relay_slot == SLOT_FIRST) begin
                  b = 8'($urandom_range(0, 255));
                  case ($urandom_range(0, 9))
                     0: frame_plan = 10'($urandom_range(0, 1023));
                     1: frame_plan = {1'b0, b, 1'b0};
                     2: frame_plan = {1'b1, b, 1'b1};
                     default: frame_plan = {1'b1, b, 1'b0};
                  endcase
               end
               w.rx_level = frame_plan[relay_slot] ^ chance(3);
            end
            default: begin
               if (relay_ticks == 0)
                  gap_plan = chance(25) ? $urandom_range(0, 300) : $urandom_range(1, 12);
               w.rx_level = (relay_ticks + 1 >= gap_plan) ? 1'b0 : 1'b1;
            end
         endcase
      end
   endtask

   task automatic offer_word(input req_word_type w, input logic typed,
                             input rsp_word_type typed_rsp);
      rsp_word_type want;
      while (chance(send_idle_pct)) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      uart_relay_step(w, want);
      queued_rsp.push_back(typed ? typed_rsp : want);
   endtask

   task automatic drain_and_set_gap(input logic [7:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (queued_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      relay_gap = value;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !chance(rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (queued_rsp.size() == 0) begin
            $error("response word with none expected: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = queued_rsp.pop_front();
            check_field("tx_level", want.tx_level, rsp_data.tx_level);
            check_field("rx_byte_valid", want.rx_byte_valid, rsp_data.rx_byte_valid);
            check_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
            check_field("frame_error", want.frame_error, rsp_data.frame_error);
            check_field("fifo_overflow", want.fifo_overflow, rsp_data.fifo_overflow);
            check_field("fifo_count", want.fifo_count, rsp_data.fifo_count);
            check_field("block_state", want.block_state, rsp_data.block_state);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("duplex_uart_relay_with_fifo test failed");
         $finish;
      end
   end

   initial begin : stimulus
      req_word_type w;
      int phase;
      int n;
      int k;
      relay_reset();
      // kind, rx, byte, typed, count, state
      dir_rows[0]  = {REQ_UNUSED, 1'b1, 8'hFF, 1'b1, 7'd0, MODE_IDLE};
      dir_rows[1]  = {REQ_TICK,   1'b0, 8'h00, 1'b1, 7'd0, MODE_IDLE};
      dir_rows[2]  = {REQ_TICK,   1'b1, 8'hFF, 1'b1, 7'd0, MODE_IDLE};
      dir_rows[3]  = {REQ_ARM,    1'b1, 8'h00, 1'b1, 7'd0, MODE_WAIT};
      dir_rows[4]  = {REQ_ARM,    1'b0, 8'h00, 1'b1, 7'd0, MODE_WAIT};
      dir_rows[5]  = {REQ_TICK,   1'b1, 8'h00, 1'b1, 7'd0, MODE_WAIT};
      dir_rows[6]  = {REQ_TICK,   1'b0, 8'h00, 1'b1, 7'd0, MODE_FRAME};
      dir_rows[7]  = {REQ_TICK,   1'b0, 8'h00, 1'b1, 7'd0, MODE_FRAME};
      // empty FIFO at start bit: back to idle
      dir_rows[8]  = {REQ_TICK,   1'b0, 8'h00, 1'b1, 7'd0, MODE_IDLE};
      dir_rows[9]  = {REQ_LOAD,   1'b1, 8'h00, 1'b1, 7'd1, MODE_IDLE};
      dir_rows[10] = {REQ_LOAD,   1'b0, 8'hFF, 1'b1, 7'd2, MODE_IDLE};
      dir_rows[11] = {REQ_LOAD,   1'b1, 8'hA5, 1'b1, 7'd3, MODE_IDLE};
      dir_rows[12] = {REQ_ARM,    1'b1, 8'h5A, 1'b1, 7'd3, MODE_WAIT};
      dir_rows[13] = {REQ_UNUSED, 1'b0, 8'h00, 1'b1, 7'd3, MODE_WAIT};
      dir_rows[14] = {REQ_TICK,   1'b0, 8'hFF, 1'b1, 7'd3, MODE_FRAME};
      dir_rows[15] = {REQ_LOAD,   1'b0, 8'h5A, 1'b1, 7'd4, MODE_FRAME};
      dir_rows[16] = {REQ_TICK,   1'b0, 8'h00, 1'b1, 7'd4, MODE_FRAME};
      dir_rows[17] = {REQ_TICK,   1'b0, 8'h00, 1'b1, 7'd3, MODE_FRAME};
      dir_rows[18] = {REQ_TICK,   1'b1, 8'h00, 1'b0, 7'd0, MODE_IDLE};
      dir_rows[19] = {REQ_TICK,   1'b0, 8'hFF, 1'b0, 7'd0, MODE_IDLE};
      dir_rows[20] = {REQ_TICK,   1'b1, 8'h00, 1'b0, 7'd0, MODE_IDLE};
      gap_list[0] = 8'd1;
      gap_list[1] = 8'd255;
      gap_list[2] = 8'd0;
      gap_list[3] = 8'($urandom_range(1, 255));
      gap_list[4] = 8'd250;
      gap_list[5] = 8'd2;
      load_pct_list[0] = 4;
      load_pct_list[1] = 3;
      load_pct_list[2] = 30;
      load_pct_list[3] = 6;
      load_pct_list[4] = 3;
      load_pct_list[5] = 25;
      send_idle_pct = 38;
      rsp_idle_pct = 49;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_ROWS; k++) begin
         w = {dir_rows[k].kind, dir_rows[k].rx, dir_rows[k].data};
         offer_word(w, dir_rows[k].typed, {12'd0, dir_rows[k].count, dir_rows[k].state});
      end

      for (phase = 0; phase < PHASES; phase++) begin
         drain_and_set_gap(gap_list[phase]);
         load_pct = load_pct_list[phase];
         if (phase < 2) begin
            send_idle_pct = 38;
            rsp_idle_pct = 49;
         end else if (phase < 4) begin
            send_idle_pct = 49;
            rsp_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (phase == 4) begin
            @(posedge clock);
            rsp_hold_cycles = 150;
         end
         for (n = 0; n < WORDS_PER_PHASE; n++) begin
            make_word(w);
            offer_word(w, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (queued_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("duplex_uart_relay_with_fifo test passed");
      else
         $display("duplex_uart_relay_with_fifo test failed");
      $finish;
   end

endmodule
